FILE: rtl/rdc_pkg.sv
// Package for the radix digit converter: field widths, symbol kinds,
// sequencer states and the reciprocal table used by the shared divider.
// No dependencies.
`default_nettype none

package rdc_pkg;

    localparam int INT_BITS    = 31;
    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 4;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int RECIP_W     = 32;
    localparam int REM_W       = 6;
    localparam int CNT_W       = $clog2(INT_BITS + 1);
    localparam int FCNT_W      = $clog2(FRAC_DIGITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    typedef enum logic [1:0] {
        KIND_MINUS = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_POINT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_MINUS,
        ST_INT,
        ST_POINT,
        ST_FRAC
    } state_t;

    // Reciprocal floor(2^32 / radix) for every legal radix.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [RADIX_W-1:0] radix);
        logic [RECIP_W-1:0] r;
        begin
            unique case (radix)
                5'd2:    r = 32'd2147483648;
                5'd3:    r = 32'd1431655765;
                5'd4:    r = 32'd1073741824;
                5'd5:    r = 32'd858993459;
                5'd6:    r = 32'd715827882;
                5'd7:    r = 32'd613566756;
                5'd8:    r = 32'd536870912;
                5'd9:    r = 32'd477218588;
                5'd10:   r = 32'd429496729;
                5'd11:   r = 32'd390451572;
                5'd12:   r = 32'd357913941;
                5'd13:   r = 32'd330382099;
                5'd14:   r = 32'd306783378;
                5'd15:   r = 32'd286331153;
                5'd16:   r = 32'd268435456;
                default: r = 32'd429496729;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/radix_digit_converter_top.sv
// Radix digit converter top level: sequencer, shared reciprocal divider,
// digit stack, fractional multiplier and output register.
// Depends on rdc_pkg.
//
// Channel   Signals                                      Direction
// input     in_valid, in_stall, negative, int_magnitude,  in (in_stall out)
//           fraction
// output    out_valid, out_stall, symbol_kind, digit,     out (out_stall in)
//           last
// config    cfg_valid, cfg_ready, cfg_data                in (cfg_ready out)
//
// Each integer digit passes through the multiply and fix-up states of the
// shared reciprocal divider; symbols then leave at one per cycle while the
// output is not stalled.
// The input stalls from acceptance until the last symbol is in the output
// register; output stalls hold the sequencer. Reset sets the radix to 10.
`default_nettype none

module radix_digit_converter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          negative,
    input  wire logic [rdc_pkg::INT_BITS-1:0]  int_magnitude,
    input  wire logic [rdc_pkg::FRAC_BITS-1:0] fraction,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         symbol_kind,
    output logic [rdc_pkg::DIGIT_W-1:0]        digit,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   cfg_data
);
    import rdc_pkg::*;

    state_t                      state_reg, state_next;
    logic [RADIX_W-1:0]          radix_reg;
    logic [INT_BITS-1:0]         mag_reg;
    logic [INT_BITS-1:0]         q0_reg;
    logic [FRAC_BITS-1:0]        frac_reg;
    logic                        neg_reg;
    logic [DIGIT_W-1:0]          stack_reg [INT_BITS];
    logic [CNT_W-1:0]            dcnt_reg;
    logic [FCNT_W-1:0]           fcnt_reg;
    logic                        out_valid_reg;
    kind_t                       kind_reg;
    logic [DIGIT_W-1:0]          digit_reg;
    logic                        last_reg;

    logic                        accept;
    logic                        slot_free;
    logic                        mul_en;
    logic                        push;
    logic                        pop;
    logic                        frac_step;
    logic                        out_load;
    kind_t                       kind_next;
    logic [DIGIT_W-1:0]          digit_next;
    logic                        last_next;

    logic [INT_BITS+RECIP_W-1:0] prod_full;
    logic [REM_W-1:0]            low_mul;
    logic [REM_W-1:0]            rem_raw;
    logic                        rem_fix;
    logic [DIGIT_W-1:0]          int_digit;
    logic [INT_BITS-1:0]         quot;
    logic [FRAC_BITS+RADIX_W-1:0] frac_prod;
    logic [DIGIT_W-1:0]          frac_digit;
    logic                        frac_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;

    assign prod_full = (INT_BITS+RECIP_W)'(mag_reg)
                     * (INT_BITS+RECIP_W)'(recip_of(radix_reg));
    assign low_mul   = q0_reg[REM_W-1:0] * REM_W'(radix_reg);
    assign rem_raw   = mag_reg[REM_W-1:0] - low_mul;
    assign rem_fix   = (rem_raw >= REM_W'(radix_reg));
    assign int_digit = rem_fix ? DIGIT_W'(rem_raw - REM_W'(radix_reg))
                               : DIGIT_W'(rem_raw);
    assign quot      = q0_reg + INT_BITS'(rem_fix);

    assign frac_prod  = (FRAC_BITS+RADIX_W)'(frac_reg) * (FRAC_BITS+RADIX_W)'(radix_reg);
    assign frac_digit = frac_prod[FRAC_BITS+DIGIT_W-1:FRAC_BITS];
    assign frac_last  = (fcnt_reg == FCNT_W'(FRAC_DIGITS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        frac_step  = 1'b0;
        out_load   = 1'b0;
        kind_next  = KIND_DIGIT;
        digit_next = '0;
        last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV_MUL;
                end
            end
            ST_DIV_MUL:
            begin
                mul_en     = 1'b1;
                state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX:
            begin
                push = 1'b1;
                if (quot != '0)
                begin
                    state_next = ST_DIV_MUL;
                end
                else if (neg_reg)
                begin
                    state_next = ST_MINUS;
                end
                else
                begin
                    state_next = ST_INT;
                end
            end
            ST_MINUS:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_MINUS;
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    pop        = 1'b1;
                    digit_next = stack_reg[0];
                    if (dcnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_POINT;
                    end
                end
            end
            ST_POINT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    kind_next  = KIND_POINT;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    frac_step  = 1'b1;
                    digit_next = frac_digit;
                    last_next  = frac_last;
                    if (frac_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= RADIX_RESET;
            dcnt_reg      <= '0;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                priority if (cfg_data < RADIX_MIN)
                begin
                    radix_reg <= RADIX_MIN;
                end
                else if (cfg_data > RADIX_MAX)
                begin
                    radix_reg <= RADIX_MAX;
                end
                else
                begin
                    radix_reg <= cfg_data;
                end
            end
            if (push)
            begin
                dcnt_reg <= dcnt_reg + CNT_W'(1);
            end
            else if (pop)
            begin
                dcnt_reg <= dcnt_reg - CNT_W'(1);
            end
            if (accept)
            begin
                fcnt_reg <= '0;
            end
            else if (frac_step)
            begin
                fcnt_reg <= fcnt_reg + FCNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg  <= int_magnitude;
            frac_reg <= fraction;
            neg_reg  <= negative;
        end
        else
        begin
            if (push)
            begin
                mag_reg <= quot;
            end
            if (frac_step)
            begin
                frac_reg <= frac_prod[FRAC_BITS-1:0];
            end
        end
        if (mul_en)
        begin
            q0_reg <= prod_full[INT_BITS+RECIP_W-1:RECIP_W];
        end
        if (push)
        begin
            stack_reg[0] <= int_digit;
            for (int i = 1; i < INT_BITS; i++)
            begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < INT_BITS - 1; i++)
            begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
        if (out_load)
        begin
            kind_reg  <= kind_next;
            digit_reg <= digit_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_kind = kind_reg;
    assign digit       = digit_reg;
    assign last        = last_reg;

`ifndef ASSERT_OFF
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= CNT_W'(INT_BITS))
        else $error("Digit stack count exceeds its depth.");

    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (dcnt_reg == '0) && !out_load)
        else $error("Input transaction accepted with digits still pending.");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && kind_next == KIND_DIGIT) |-> (RADIX_W'(digit_next) < radix_reg))
        else $error("Emitted digit is not below the radix.");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (state_reg == ST_IDLE) && (dcnt_reg == '0))
        else $error("Run ended without returning to idle.");
`endif

endmodule

`default_nettype wire
